// ===== design/segment_bounding_box_macros.svh =====
// Assertion macros for the segment bounding box block.
// Used by design/segment_bounding_box.sv; relies on the clock and reset names of that module.
`ifndef SEGMENT_BOUNDING_BOX_MACROS_SVH
`define SEGMENT_BOUNDING_BOX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sbb_pkg.sv =====
// Types and codes shared by the segment bounding box block.
// Has no dependencies; imported by design/segment_bounding_box.sv.
package sbb_pkg;

   localparam int unsigned SEG_W   = 10;
   localparam int unsigned COORD_W = 12;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [SEG_W-1:0]   segment_id;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } bbox_req_type;

   typedef struct packed {
      logic [SEG_W-1:0]   segment_echo;
      logic               found;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] right;
   } bbox_rsp_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } bbox_state_type;

endpackage

// ===== design/segment_bounding_box.sv =====
// Segment bounding box: per-label enclosing rectangles kept in one on-chip memory.
// Depends on design/sbb_pkg.sv and design/segment_bounding_box_macros.svh.
//
// Usage. Requests enter on req_valid / req_stall / req_data. A pixel request
// (req_type = 0) widens the rectangle of its label and gives no response. A read
// request (req_type = 1) returns that label's rectangle on rsp_valid / rsp_stall /
// rsp_data, with found = 0 and zero bounds for an empty or out-of-range label, and
// empties the entry for the next frame. Responses come in request order.
// Each request takes one read-modify-write of the bounds memory: the read is issued
// as the request is accepted, the merged entry is written back as the request leaves
// the second stage, and a one-entry bypass serves a request that follows its own
// label. One request is accepted per cycle while req_stall is low; a read's response
// is valid once the read has left the second stage for the response register.
// The response register decouples the two sides: a stalled response holds only a
// following read request, and only while rsp_stall stays high.
// After reset the block sweeps the memory once, one entry per cycle, to empty every
// label; req_stall stays high until all min(SEGMENTS, 1024) entries (1024 by default) are empty.
module segment_bounding_box
   import sbb_pkg::*;
#(
   parameter int SEGMENTS   = 1024,
   parameter int COORD_BITS = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bbox_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output bbox_rsp_type rsp_data
);

`include "segment_bounding_box_macros.svh"

   // Only labels that fit the label field can ever be addressed.
   localparam int DEPTH = (SEGMENTS < (1 << SEG_W)) ? SEGMENTS : (1 << SEG_W);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int EW    = 4 * CW + 1;

   // Entry layout: valid mark, then top, left, bottom and right.
   logic [EW-1:0] mem [DEPTH];

   bbox_state_type state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic           clearing;

   logic           s1_valid_ff, s1_valid_in;
   bbox_req_type   s1_req_ff;
   logic [EW-1:0]  rd_data_ff;
   logic           fwd_valid_ff;
   logic [AW-1:0]  fwd_addr_ff;
   logic [EW-1:0]  fwd_data_ff;
   logic           out_valid_ff, out_valid_in;
   bbox_rsp_type   out_data_ff, out_data_in;

   logic           req_accept;
   logic           s1_is_read, s1_adv, s1_in_range;
   logic [AW-1:0]  s1_addr;
   logic [EW-1:0]  cur, upd;
   logic           cur_valid;
   logic [CW-1:0]  cur_top, cur_left, cur_bottom, cur_right, pix_r, pix_c;
   logic           wr_en, mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [EW-1:0]  mem_wdata;

   // Reset sweep state machine.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) state_in = ST_RUN;
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing   = (state_ff == ST_CLEAR);
      clr_cnt_in = clearing ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Handshake and stage control.
   always_comb begin
      s1_is_read  = (s1_req_ff.req_type == REQ_READ);
      s1_adv      = s1_valid_ff && !(s1_is_read && out_valid_ff && rsp_stall);
      req_stall   = clearing || (s1_valid_ff && !s1_adv);
      req_accept  = req_valid && !req_stall;
      s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
   end

   // Merge of the stored entry with the request in the second stage.
   always_comb begin
      s1_addr     = s1_req_ff.segment_id[AW-1:0];
      s1_in_range = ({22'd0, s1_req_ff.segment_id} < 32'(SEGMENTS));
      cur         = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_data_ff : rd_data_ff;
      cur_valid   = cur[EW-1];
      cur_top     = cur[4*CW-1:3*CW];
      cur_left    = cur[3*CW-1:2*CW];
      cur_bottom  = cur[2*CW-1:CW];
      cur_right   = cur[CW-1:0];
      pix_r       = s1_req_ff.row[CW-1:0];
      pix_c       = s1_req_ff.col[CW-1:0];

      if (s1_is_read) begin
         // A read empties the entry; the bounds are left as they are.
         upd = {1'b0, cur[EW-2:0]};
      end else if (!cur_valid) begin
         upd = {1'b1, pix_r, pix_c, pix_r, pix_c};
      end else begin
         upd = {1'b1,
                (pix_r < cur_top)    ? pix_r : cur_top,
                (pix_c < cur_left)   ? pix_c : cur_left,
                (pix_r > cur_bottom) ? pix_r : cur_bottom,
                (pix_c > cur_right)  ? pix_c : cur_right};
      end

      wr_en = s1_adv && s1_in_range && (!s1_is_read || cur_valid);

      out_data_in.segment_echo = s1_req_ff.segment_id;
      out_data_in.found        = s1_in_range && cur_valid;
      out_data_in.top          = out_data_in.found ? COORD_W'(cur_top)    : '0;
      out_data_in.left         = out_data_in.found ? COORD_W'(cur_left)   : '0;
      out_data_in.bottom       = out_data_in.found ? COORD_W'(cur_bottom) : '0;
      out_data_in.right        = out_data_in.found ? COORD_W'(cur_right)  : '0;

      if (s1_adv && s1_is_read) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      mem_we    = clearing || wr_en;
      mem_waddr = clearing ? clr_cnt_ff : s1_addr;
      mem_wdata = clearing ? '0 : upd;
   end

   // Bounds memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (req_accept) rd_data_ff <= mem[req_data.segment_id[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // The bypass holds the write made as the current second-stage request was read.
         if (s1_adv) fwd_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) s1_req_ff <= req_data;
      if (s1_adv) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= upd;
      end
      if (s1_adv && s1_is_read) out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `SBB_ASSERT_NOW(a_no_work_in_sweep, clearing, !s1_valid_ff && !req_accept,
      "request in flight during the reset sweep")
   `SBB_ASSERT_NOW(a_sweep_ends_at_top, clearing && (state_in == ST_RUN),
      clr_cnt_ff == AW'(DEPTH - 1), "reset sweep ended before the last entry")
   `SBB_ASSERT_NEXT(a_held_read_data, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(rd_data_ff) && $stable(s1_req_ff),
      "held request lost its read data")
   `SBB_ASSERT_NEXT(a_read_gives_response, s1_adv && s1_is_read,
      out_valid_ff && (out_data_ff.segment_echo == $past(s1_req_ff.segment_id)),
      "read request produced no response")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for segment_bounding_box: pixel and read requests are driven against a
// per-label rectangle predictor, and every response is checked field by field.
// Depends on design/sbb_pkg.sv and design/segment_bounding_box.sv.
module tb_top;
   import sbb_pkg::*;

   localparam int SEGMENT_COUNT = 1024;
   localparam int COORD_MAX     = (1 << COORD_W) - 1;
   localparam int SEG_MAX       = (1 << SEG_W) - 1;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   bbox_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   bbox_rsp_type rsp_data;

   // Predicted rectangle of every label.
   bit                 label_live [SEGMENT_COUNT];
   logic [COORD_W-1:0] min_row    [SEGMENT_COUNT];
   logic [COORD_W-1:0] min_col    [SEGMENT_COUNT];
   logic [COORD_W-1:0] max_row    [SEGMENT_COUNT];
   logic [COORD_W-1:0] max_col    [SEGMENT_COUNT];
   bbox_rsp_type       pending_boxes [$];
   bbox_rsp_type       want_box;

   int error_count       = 0;
   int requests_sent     = 0;
   int boxes_checked     = 0;
   int found_count       = 0;
   int input_hold_cycles = 0;
   int send_idle_pct     = 0;
   int rsp_stall_pct     = 0;
   int hold_request      = 0;
   int hold_left         = 0;

   segment_bounding_box DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 100)
         $display("MISMATCH %s at %0t: got %0d, expected %0d", what, $time, got, want);
   endtask

   // Widens or reads and empties the predicted rectangle of one label.
   function automatic void apply_request(input bbox_req_type r);
      bbox_rsp_type box;
      int unsigned  s;
      s = r.segment_id;
      if (r.req_type == REQ_PIXEL) begin
         if (s < SEGMENT_COUNT) begin
            if (!label_live[s]) begin
               label_live[s] = 1'b1;
               min_row[s] = r.row;
               max_row[s] = r.row;
               min_col[s] = r.col;
               max_col[s] = r.col;
            end else begin
               if (r.row < min_row[s]) min_row[s] = r.row;
               if (r.row > max_row[s]) max_row[s] = r.row;
               if (r.col < min_col[s]) min_col[s] = r.col;
               if (r.col > max_col[s]) max_col[s] = r.col;
            end
         end
      end else begin
         box = '0;
         box.segment_echo = r.segment_id;
         if (s < SEGMENT_COUNT && label_live[s]) begin
            box.found  = 1'b1;
            box.top    = min_row[s];
            box.left   = min_col[s];
            box.bottom = max_row[s];
            box.right  = max_col[s];
            label_live[s] = 1'b0;
         end
         pending_boxes = {pending_boxes, box};
      end
   endfunction

   function automatic bbox_req_type make_req(input logic kind, input int seg,
                                             input int r, input int c);
      bbox_req_type q;
      q.req_type   = kind;
      q.segment_id = SEG_W'(seg);
      q.row        = COORD_W'(r);
      q.col        = COORD_W'(c);
      return q;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input bbox_req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
         input_hold_cycles++;
      end
      apply_request(r);
      requests_sent++;
      @(negedge clock);
   endtask

   // Response side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_boxes.size() == 0) begin
            report_mismatch("unexpected response, label", rsp_data.segment_echo, -1);
         end else begin
            want_box = pending_boxes.pop_front();
            boxes_checked++;
            if (want_box.found) found_count++;
            if (rsp_data.segment_echo !== want_box.segment_echo)
               report_mismatch("segment_echo", rsp_data.segment_echo, want_box.segment_echo);
            if (rsp_data.found !== want_box.found)
               report_mismatch("found", rsp_data.found, want_box.found);
            if (rsp_data.top !== want_box.top)
               report_mismatch("top", rsp_data.top, want_box.top);
            if (rsp_data.left !== want_box.left)
               report_mismatch("left", rsp_data.left, want_box.left);
            if (rsp_data.bottom !== want_box.bottom)
               report_mismatch("bottom", rsp_data.bottom, want_box.bottom);
            if (rsp_data.right !== want_box.right)
               report_mismatch("right", rsp_data.right, want_box.right);
         end
      end
   end

   task automatic test_directed_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(make_req(REQ_PIXEL, 0, 0, 0));
      send_request(make_req(REQ_READ, 0, 0, 0));
      // A second read of the same label must find it emptied.
      send_request(make_req(REQ_READ, 0, 0, 0));
      send_request(make_req(REQ_READ, SEG_MAX, COORD_MAX, COORD_MAX));
      send_request(make_req(REQ_PIXEL, SEG_MAX, COORD_MAX, COORD_MAX));
      send_request(make_req(REQ_PIXEL, SEG_MAX, 0, 0));
      send_request(make_req(REQ_READ, SEG_MAX, 0, 0));
      // A pixel straight after the read must start a fresh rectangle.
      send_request(make_req(REQ_PIXEL, SEG_MAX, 2048, 1));
      send_request(make_req(REQ_READ, SEG_MAX, 1234, 777));
      send_request(make_req(REQ_PIXEL, 5, 100, 200));
      send_request(make_req(REQ_PIXEL, 5, 50, 300));
      send_request(make_req(REQ_PIXEL, 5, 150, 100));
      send_request(make_req(REQ_PIXEL, 5, 120, 250));
      send_request(make_req(REQ_READ, 5, 0, 0));
      send_request(make_req(REQ_PIXEL, 'h2AA, 'hAAA, 'h555));
      send_request(make_req(REQ_PIXEL, 'h155, 'h555, 'hAAA));
      send_request(make_req(REQ_READ, 'h2AA, 0, 0));
      send_request(make_req(REQ_READ, 'h155, 0, 0));
   endtask

   // Frames of a few labels: pixels in a random window, then a read of each label,
   // with stray pixels, stray reads and skipped reads mixed in.
   task automatic test_frames(input int items, input int idle_pct, input int stall_pct);
      int sent;
      int n_labels;
      int base;
      int n_pixels;
      int row_lo;
      int row_hi;
      int col_lo;
      int col_hi;
      int seg;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         n_labels = $urandom_range(6, 1);
         base     = $urandom_range(SEGMENT_COUNT - 8);
         n_pixels = $urandom_range(24, 2);
         if ($urandom_range(4) == 0) begin
            row_lo = 0;
            row_hi = COORD_MAX;
            col_lo = 0;
            col_hi = COORD_MAX;
         end else begin
            row_lo = $urandom_range(COORD_MAX);
            row_hi = $urandom_range(COORD_MAX, row_lo);
            col_lo = $urandom_range(COORD_MAX);
            col_hi = $urandom_range(COORD_MAX, col_lo);
         end
         for (int i = 0; i < n_pixels; i++) begin
            seg = base + $urandom_range(n_labels - 1);
            if ($urandom_range(19) == 0) seg = $urandom_range(SEG_MAX);
            send_request(make_req(REQ_PIXEL, seg, $urandom_range(row_hi, row_lo),
                                  $urandom_range(col_hi, col_lo)));
            sent++;
         end
         for (int k = 0; k < n_labels; k++) begin
            if ($urandom_range(7) != 0) begin
               send_request(make_req(REQ_READ, base + k, $urandom_range(COORD_MAX),
                                     $urandom_range(COORD_MAX)));
               sent++;
            end
         end
         if ($urandom_range(3) == 0) begin
            send_request(make_req(REQ_READ, $urandom_range(SEG_MAX),
                                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX)));
            sent++;
         end
      end
   endtask

   // The response side holds off for a long stretch while requests keep coming,
   // so the block must stall its input.
   task automatic test_backpressure();
      int seg;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      input_hold_cycles = 0;
      hold_request = 400;
      for (int k = 0; k < 120; k++) begin
         seg = $urandom_range(15);
         if (k % 3 == 0)
            send_request(make_req(REQ_PIXEL, seg, $urandom_range(COORD_MAX),
                                  $urandom_range(COORD_MAX)));
         else
            send_request(make_req(REQ_READ, seg, 0, 0));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_frames(400, 0, 0);
      test_frames(400, 52, 0);
      test_frames(400, 0, 52);
      test_frames(400, 32, 32);
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d requests; checked %0d rectangles, %0d of them non-empty.",
               requests_sent, boxes_checked, found_count);
      $display("Input was held back for %0d cycles during the long output hold-off.",
               input_hold_cycles);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/sbb_pkg.sv
design/segment_bounding_box.sv
verif/tb_top.sv
